[sv/lbsb_pkg.sv]
// Shared types, constants and elaboration-time tables for the log-band spectrum bar core.
// Holds the log2 and band edge table builders and the bar level update function.
// No dependencies.
`timescale 1ns / 1ps

package lbsb_pkg;

	localparam int BINS        = 256;
	localparam int BIN_AW      = 8;
	localparam int MAG_W       = 15;
	localparam int PEAK_LSB    = 7;
	localparam int Y_W         = 8;
	localparam int ROWS_W      = 10;
	localparam int FALL_W      = 12;
	localparam int LEVEL_W     = 18;
	localparam int LVL_PAIR_W  = 2 * LEVEL_W;
	localparam int SPEC_W      = 2 * MAG_W;
	localparam int INDEX_W     = 6;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;
	localparam int LOG_W       = 27;
	localparam int FRAC_W      = 24;
	localparam int PROD_W      = LOG_W + ROWS_W;
	localparam int SCALED_W    = PROD_W + 3;
	localparam int MAG_SH      = 29;
	localparam int DPROD_W     = FALL_W + ROWS_W;
	localparam int RECIP_W     = 23;
	localparam int RECIP_SH    = 26;
	localparam int DECAY_W     = 19;
	localparam int MAX_COLUMNS = 64;
	localparam int DEF_COLUMNS = 32;
	localparam int EDGE_DEPTH  = MAX_COLUMNS + 1;
	localparam int EDGE_IDX_W  = 7;

	localparam logic [ROWS_W-1:0]  ROWS_RESET    = 10'd64;
	localparam logic [FALL_W-1:0]  FALLOFF_RESET = 12'd307;
	// ceil(2^26 / 15): exact floor division by 15 for 22-bit products
	localparam logic [RECIP_W-1:0] RECIP_15      = 23'd4473925;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS    = 2'd0,
		CFG_FALLOFF = 2'd1
	} lbsb_cfg_t;

	typedef enum logic [3:0] {
		S_RECV,
		S_START,
		S_SCAN,
		S_DRAIN,
		S_MUL,
		S_MAG,
		S_WB,
		S_ERD,
		S_ELOAD,
		S_EWAIT
	} lbsb_state_t;

	typedef struct packed {
		logic clr;
		logic wr_en;
		logic rd_en;
	} lvl_ctl_t;

	typedef logic [LOG_W-1:0] log2_tab_t [BINS];
	typedef logic [BIN_AW-1:0] edge_tab_t [EDGE_DEPTH];

	// log2 in Q3.24, fraction by repeated squaring of the Q1.30 mantissa
	function automatic logic [LOG_W-1:0] log2_q24(input logic [Y_W-1:0] y);
		logic [2:0]        n;
		logic [63:0]       m;
		logic [FRAC_W-1:0] frac;
		int                k;
		int                b;
		n    = '0;
		frac = '0;
		for (k = 1; k < Y_W; k++) begin
			if ((y >> k) != '0) begin
				n = 3'(k);
			end
		end
		m = (64'(y) << 30) >> n;
		for (b = FRAC_W - 1; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= 64'd2147483648) begin
				m       = m >> 1;
				frac[b] = 1'b1;
			end
		end
		if (y == '0) begin
			return '0;
		end
		return {n, frac};
	endfunction

	function automatic log2_tab_t log2_tab();
		log2_tab_t t;
		int        i;
		for (i = 0; i < BINS; i++) begin
			t[i] = log2_q24(Y_W'(i));
		end
		return t;
	endfunction

	// floor(255^(i/columns)) with both ends pinned
	function automatic edge_tab_t edge_tab(input int columns);
		edge_tab_t         t;
		log2_tab_t         l;
		logic [63:0]       l255;
		logic [BIN_AW-1:0] best;
		int                i;
		int                e;
		l    = log2_tab();
		l255 = 64'(l[255]);
		for (i = 0; i < EDGE_DEPTH; i++) begin
			t[i] = 8'd255;
		end
		t[0] = 8'd1;
		for (i = 1; i < columns; i++) begin
			best = 8'd1;
			for (e = 1; e < BINS; e++) begin
				if (64'(columns) * 64'(l[e]) <= 64'(i) * l255) begin
					best = BIN_AW'(e);
				end
			end
			t[i] = best;
		end
		t[columns] = 8'd255;
		return t;
	endfunction

	// drop by the decay step, then rise to the new magnitude
	function automatic logic [LEVEL_W-1:0] level_next(
		input logic [LEVEL_W-1:0] lv,
		input logic [ROWS_W-1:0]  mag,
		input logic [DECAY_W-1:0] decay
	);
		logic [DECAY_W-1:0] lv_w;
		logic [LEVEL_W-1:0] dec;
		logic [LEVEL_W-1:0] tgt;
		lv_w = DECAY_W'(lv);
		dec  = (lv_w > decay) ? LEVEL_W'(lv_w - decay) : '0;
		tgt  = {mag, 8'h00};
		return (tgt > dec) ? tgt : dec;
	endfunction

endpackage

[sv/log_band_spectrum_bars_core.sv]
// Log-band spectrum bar core: stores a stereo frame of 256 bins, then sweeps the bands.
// Bins: one per cycle in the receive state only. Then per column: start, scan of the band
// (one bin if empty) on the single spectrum RAM read port, drain, mul, mag and write-back.
// Then 2*COLUMNS results, index order (level RAM read + output reg).
// Reset: config registers to rows 64 / falloff 307, all bar levels zero, bin counter zero.
// Depends on lbsb_pkg, lbsb_spec_ram, lbsb_level_ram, lbsb_mag.
`timescale 1ns / 1ps

module log_band_spectrum_bars_core #(
	parameter int COLUMNS = lbsb_pkg::DEF_COLUMNS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [lbsb_pkg::IN_TDATA_W-1:0]       s_tdata,  // left_bin, right_bin, zero pad
	input  logic                                  s_tlast,  // last_bin
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [lbsb_pkg::OUT_TDATA_W-1:0]      m_tdata,  // bar_index, bar_level
	output logic                                  m_tlast,  // last_bar
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lbsb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lbsb_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CW = $clog2(COLUMNS);
	localparam int JW = $clog2(2 * COLUMNS);
	localparam int EW = lbsb_pkg::EDGE_IDX_W;
	localparam int AW = lbsb_pkg::BIN_AW;
	localparam int MW = lbsb_pkg::MAG_W;
	localparam int LW = lbsb_pkg::LEVEL_W;
	localparam lbsb_pkg::edge_tab_t EDGE_TAB = lbsb_pkg::edge_tab(COLUMNS);

	lbsb_pkg::lbsb_state_t            state_q;
	lbsb_pkg::lbsb_state_t            state_d;
	lbsb_pkg::lvl_ctl_t               lvl_ctl;

	logic                             in_acc;
	logic                             out_acc;
	logic                             cfg_acc;
	logic [lbsb_pkg::ROWS_W-1:0]      rows_q;
	logic [lbsb_pkg::FALL_W-1:0]      falloff_q;
	logic [AW-1:0]                    bin_cnt_q;
	logic [CW-1:0]                    col_q;
	logic [JW-1:0]                    j_q;
	logic [AW-1:0]                    rd_addr_q;
	logic [AW-1:0]                    end_q;
	logic                             spec_re;
	logic                             rd_vld_s1;
	logic [lbsb_pkg::SPEC_W-1:0]      spec_rdata;
	logic [MW-1:0]                    max_l_q;
	logic [MW-1:0]                    max_r_q;
	logic [AW-1:0]                    edge_lo;
	logic [AW-1:0]                    edge_hi;
	logic                             band_empty;
	logic [CW-1:0]                    lvl_rd_addr;
	logic [lbsb_pkg::LVL_PAIR_W-1:0]  lvl_rdata;
	logic [lbsb_pkg::LVL_PAIR_W-1:0]  lvl_wdata;
	logic [lbsb_pkg::ROWS_W-1:0]      mag_l;
	logic [lbsb_pkg::ROWS_W-1:0]      mag_r;
	logic [lbsb_pkg::DECAY_W-1:0]     decay;
	logic                             emit_right;
	logic [CW-1:0]                    emit_col;
	logic                             m_valid_q;
	logic [lbsb_pkg::INDEX_W-1:0]     m_index_q;
	logic [LW-1:0]                    m_level_q;
	logic                             m_last_q;

	assign in_acc    = s_tvalid && s_tready;
	assign out_acc   = m_tvalid && m_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == lbsb_pkg::S_RECV);

	assign edge_lo    = EDGE_TAB[EW'(col_q)];
	assign edge_hi    = EDGE_TAB[EW'(col_q) + EW'(1)];
	assign band_empty = (edge_lo == edge_hi);

	assign emit_right = (j_q >= JW'(COLUMNS));
	assign emit_col   = emit_right ? CW'(JW'(2 * COLUMNS - 1) - j_q) : CW'(j_q);

	assign lvl_wdata = {lbsb_pkg::level_next(lvl_rdata[2*LW-1:LW], mag_r, decay),
	                    lbsb_pkg::level_next(lvl_rdata[LW-1:0], mag_l, decay)};

	always_comb begin
		state_d     = state_q;
		lvl_ctl     = '0;
		lvl_rd_addr = col_q;
		spec_re     = 1'b0;
		case (state_q)
			lbsb_pkg::S_RECV: begin
				if (in_acc && s_tlast) begin
					state_d = lbsb_pkg::S_START;
				end
			end
			lbsb_pkg::S_START: begin
				state_d = lbsb_pkg::S_SCAN;
			end
			lbsb_pkg::S_SCAN: begin
				spec_re = 1'b1;
				if (rd_addr_q == end_q) begin
					state_d = lbsb_pkg::S_DRAIN;
				end
			end
			lbsb_pkg::S_DRAIN: begin
				state_d = lbsb_pkg::S_MUL;
			end
			lbsb_pkg::S_MUL: begin
				state_d = lbsb_pkg::S_MAG;
			end
			lbsb_pkg::S_MAG: begin
				lvl_ctl.rd_en = 1'b1;
				state_d       = lbsb_pkg::S_WB;
			end
			lbsb_pkg::S_WB: begin
				lvl_ctl.wr_en = 1'b1;
				state_d = (col_q == CW'(COLUMNS - 1)) ? lbsb_pkg::S_ERD : lbsb_pkg::S_START;
			end
			lbsb_pkg::S_ERD: begin
				lvl_ctl.rd_en = 1'b1;
				lvl_rd_addr   = emit_col;
				state_d       = lbsb_pkg::S_ELOAD;
			end
			lbsb_pkg::S_ELOAD: begin
				state_d = lbsb_pkg::S_EWAIT;
			end
			lbsb_pkg::S_EWAIT: begin
				if (out_acc) begin
					state_d = m_last_q ? lbsb_pkg::S_RECV : lbsb_pkg::S_ERD;
				end
			end
			default: begin
				state_d = lbsb_pkg::S_RECV;
			end
		endcase
		lvl_ctl.clr = cfg_acc && (cfg_index == lbsb_pkg::CFG_ROWS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbsb_pkg::S_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= lbsb_pkg::ROWS_RESET;
			falloff_q <= lbsb_pkg::FALLOFF_RESET;
			bin_cnt_q <= '0;
			col_q     <= '0;
			j_q       <= '0;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= spec_re;
			if (cfg_acc) begin
				case (cfg_index)
					lbsb_pkg::CFG_ROWS:    rows_q    <= cfg_data[lbsb_pkg::ROWS_W-1:0];
					lbsb_pkg::CFG_FALLOFF: falloff_q <= cfg_data[lbsb_pkg::FALL_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				bin_cnt_q <= s_tlast ? '0 : bin_cnt_q + AW'(1);
				col_q     <= '0;
			end
			if (state_q == lbsb_pkg::S_WB) begin
				if (col_q == CW'(COLUMNS - 1)) begin
					j_q <= '0;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (state_q == lbsb_pkg::S_ELOAD) begin
				m_valid_q <= 1'b1;
			end else if (out_acc) begin
				m_valid_q <= 1'b0;
				j_q       <= j_q + JW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lbsb_pkg::S_START) begin
			rd_addr_q <= band_empty ? AW'(col_q) : edge_lo;
			end_q     <= band_empty ? AW'(col_q) : edge_hi - AW'(1);
			max_l_q   <= '0;
			max_r_q   <= '0;
		end else begin
			if (state_q == lbsb_pkg::S_SCAN) begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
			if (rd_vld_s1) begin
				if (spec_rdata[MW-1:0] > max_l_q) begin
					max_l_q <= spec_rdata[MW-1:0];
				end
				if (spec_rdata[2*MW-1:MW] > max_r_q) begin
					max_r_q <= spec_rdata[2*MW-1:MW];
				end
			end
		end
		if (state_q == lbsb_pkg::S_ELOAD) begin
			m_index_q <= lbsb_pkg::INDEX_W'(j_q);
			m_level_q <= emit_right ? lvl_rdata[2*LW-1:LW] : lvl_rdata[LW-1:0];
			m_last_q  <= (j_q == JW'(2 * COLUMNS - 1));
		end
	end

	lbsb_spec_ram u_spec_ram (
		.clk   (clk),
		.we    (in_acc),
		.waddr (bin_cnt_q),
		.wdata ({s_tdata[2*MW-1:MW], s_tdata[MW-1:0]}),
		.re    (spec_re),
		.raddr (rd_addr_q),
		.rdata (spec_rdata)
	);

	lbsb_level_ram #(
		.DEPTH (COLUMNS)
	) u_level_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (lvl_ctl),
		.wr_addr (col_q),
		.rd_addr (lvl_rd_addr),
		.wdata   (lvl_wdata),
		.rdata   (lvl_rdata)
	);

	lbsb_mag u_mag (
		.clk     (clk),
		.rows    (rows_q),
		.falloff (falloff_q),
		.peak_l  (max_l_q),
		.peak_r  (max_r_q),
		.mag_l   (mag_l),
		.mag_r   (mag_r),
		.decay   (decay)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_level_q, m_index_q};
	assign m_tlast  = m_last_q;

endmodule

[sv/lbsb_spec_ram.sv]
// Stereo spectrum store: 256 entries of left and right magnitude, one write and one read port.
// Read data registered, valid in the cycle after a read. Depends on lbsb_pkg.
`timescale 1ns / 1ps

module lbsb_spec_ram (
	input  logic                               clk,
	input  logic                               we,
	input  logic [lbsb_pkg::BIN_AW-1:0]        waddr,
	input  logic [lbsb_pkg::SPEC_W-1:0]        wdata,
	input  logic                               re,
	input  logic [lbsb_pkg::BIN_AW-1:0]        raddr,
	output logic [lbsb_pkg::SPEC_W-1:0]        rdata
);

	logic [lbsb_pkg::SPEC_W-1:0] mem_q [lbsb_pkg::BINS];
	logic [lbsb_pkg::SPEC_W-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem_q[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

[sv/lbsb_level_ram.sv]
// Bar level store: one entry per column holding the right and left levels.
// Per-entry valid bits make unwritten or cleared entries read as zero. Depends on lbsb_pkg.
`timescale 1ns / 1ps

module lbsb_level_ram #(
	parameter int DEPTH = lbsb_pkg::DEF_COLUMNS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lbsb_pkg::lvl_ctl_t                  ctl,
	input  logic [$clog2(DEPTH)-1:0]            wr_addr,
	input  logic [$clog2(DEPTH)-1:0]            rd_addr,
	input  logic [lbsb_pkg::LVL_PAIR_W-1:0]     wdata,
	output logic [lbsb_pkg::LVL_PAIR_W-1:0]     rdata
);

	logic [lbsb_pkg::LVL_PAIR_W-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]                valid_q;
	logic [lbsb_pkg::LVL_PAIR_W-1:0] rdata_s1;
	logic                            vld_s1;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rdata = vld_s1 ? rdata_s1 : '0;

endmodule

[sv/lbsb_mag.sv]
// Magnitude mapping for a left and right band peak: log2 table, scale by rows, clamp.
// Two register stages; also derives the decay step from the registers. Depends on lbsb_pkg.
`timescale 1ns / 1ps

module lbsb_mag (
	input  logic                              clk,
	input  logic [lbsb_pkg::ROWS_W-1:0]       rows,
	input  logic [lbsb_pkg::FALL_W-1:0]       falloff,
	input  logic [lbsb_pkg::MAG_W-1:0]        peak_l,
	input  logic [lbsb_pkg::MAG_W-1:0]        peak_r,
	output logic [lbsb_pkg::ROWS_W-1:0]       mag_l,
	output logic [lbsb_pkg::ROWS_W-1:0]       mag_r,
	output logic [lbsb_pkg::DECAY_W-1:0]      decay
);

	localparam int PW = lbsb_pkg::PROD_W;
	localparam int SW = lbsb_pkg::SCALED_W;
	localparam int DW = lbsb_pkg::DPROD_W + lbsb_pkg::RECIP_W;
	localparam lbsb_pkg::log2_tab_t LOG2_TAB = lbsb_pkg::log2_tab();

	logic [PW-1:0]                       prod_l_s1;
	logic [PW-1:0]                       prod_r_s1;
	logic [SW-1:0]                       scaled_l;
	logic [SW-1:0]                       scaled_r;
	logic [lbsb_pkg::ROWS_W:0]           m_l;
	logic [lbsb_pkg::ROWS_W:0]           m_r;
	logic [lbsb_pkg::ROWS_W-1:0]         mag_l_s2;
	logic [lbsb_pkg::ROWS_W-1:0]         mag_r_s2;
	logic [lbsb_pkg::DPROD_W-1:0]        dprod_q;
	logic [DW-1:0]                       dmul;
	logic [lbsb_pkg::DECAY_W-1:0]        decay_q;

	always_comb begin
		scaled_l = SW'({prod_l_s1, 2'b00}) + SW'(prod_l_s1);
		scaled_r = SW'({prod_r_s1, 2'b00}) + SW'(prod_r_s1);
		m_l      = scaled_l[SW-1:lbsb_pkg::MAG_SH];
		m_r      = scaled_r[SW-1:lbsb_pkg::MAG_SH];
		dmul     = DW'(dprod_q) * DW'(lbsb_pkg::RECIP_15);
	end

	always_ff @(posedge clk) begin
		prod_l_s1 <= PW'(LOG2_TAB[peak_l[lbsb_pkg::MAG_W-1:lbsb_pkg::PEAK_LSB]]) * PW'(rows);
		prod_r_s1 <= PW'(LOG2_TAB[peak_r[lbsb_pkg::MAG_W-1:lbsb_pkg::PEAK_LSB]]) * PW'(rows);
		mag_l_s2  <= (m_l > {1'b0, rows}) ? rows : m_l[lbsb_pkg::ROWS_W-1:0];
		mag_r_s2  <= (m_r > {1'b0, rows}) ? rows : m_r[lbsb_pkg::ROWS_W-1:0];
		dprod_q   <= lbsb_pkg::DPROD_W'(falloff) * lbsb_pkg::DPROD_W'(rows);
		decay_q   <= dmul[DW-1:lbsb_pkg::RECIP_SH];
	end

	assign mag_l = mag_l_s2;
	assign mag_r = mag_r_s2;
	assign decay = decay_q;

endmodule

[sv/lbsb_checker.sv]
// Port-level checks for the log-band spectrum bar core, bound to the top level.
// Depends on log_band_spectrum_bars_core.
`timescale 1ns / 1ps

module lbsb_checker #(
	parameter int COLUMNS = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// no bin transaction while a result is pending
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while result pending");

	// a frame end starts the band sweep
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready && !m_tvalid)
		else $error("frame end did not start sweep");

	// the final bar carries the top index
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[5:0] == 6'(2 * COLUMNS - 1))
		else $error("last bar index wrong");

endmodule

bind log_band_spectrum_bars_core lbsb_checker #(
	.COLUMNS (COLUMNS)
) u_lbsb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

[bench/tb_log_band_spectrum_bars_core.sv]
// Self-checking bench for log_band_spectrum_bars_core: streams stereo bin frames, rewrites
// rows and falloff between phases and checks every bar transaction against its own bar model.
// Depends on lbsb_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_log_band_spectrum_bars_core;
	import lbsb_pkg::*;

	localparam int COLS        = DEF_COLUMNS;
	localparam int BARS        = 2 * COLS;
	localparam int IDLE_LIMIT  = 20000;
	localparam int SETTLE      = 16;
	localparam int PHASE_ITEMS = 30;
	localparam int MAX_REPORTS = 10;

	localparam int FILL_SPREAD = 0;
	localparam int FILL_FULL   = 1;
	localparam int FILL_ZERO   = 2;
	localparam int FILL_TOP    = 3;
	localparam int FILL_MIXED  = 4;

	localparam logic [MAG_W-1:0] MAG_TOP = '1;

	typedef struct packed {
		logic [MAG_W-1:0] left;
		logic [MAG_W-1:0] right;
		logic             last;
	} bin_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} bar_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	bin_t        bins_pending[$];
	bar_t        bars_due[$];
	bin_t        held;
	bar_t        got;
	bar_t        want;

	logic [MAG_W-1:0] left_mag[BINS];
	logic [MAG_W-1:0] right_mag[BINS];
	int unsigned      bar_level_q[BARS];
	int unsigned      band_edge[COLS+1];
	logic [BIN_AW-1:0] bin_slot;
	int unsigned      rows_cfg;
	int unsigned      falloff_cfg;

	int send_idle_pct;
	int recv_idle_pct;
	int fault_count;
	int bins_in;
	int frames_in;
	int bars_seen;
	int cfg_writes;
	int idle_cycles;

	log_band_spectrum_bars_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// log2 of 1..255 in Q3.24 by repeated squaring, each square truncated
	function automatic longint unsigned bin_log2(int unsigned y);
		int unsigned       n;
		longint unsigned   m;
		longint unsigned   fr;
		int                b;
		if (y == 0) begin
			return 0;
		end
		n  = 0;
		fr = 0;
		while (n < 31 && (y >> (n + 1)) != 0) begin
			n++;
		end
		m = (64'(y) << 30) >> n;
		for (b = FRAC_W - 1; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= 64'h8000_0000) begin
				m  = m >> 1;
				fr = fr | (64'd1 << b);
			end
		end
		return (64'(n) << FRAC_W) | fr;
	endfunction

	function automatic int unsigned band_peak(bit right_ch, int col);
		int unsigned lo;
		int unsigned hi;
		int unsigned peak;
		int unsigned v;
		int unsigned k;
		lo = band_edge[col];
		hi = band_edge[col+1];
		if (lo == hi) begin
			return right_ch ? right_mag[col] : left_mag[col];
		end
		peak = 0;
		for (k = lo; k < hi; k++) begin
			v = right_ch ? right_mag[k] : left_mag[k];
			if (v > peak) begin
				peak = v;
			end
		end
		return peak;
	endfunction

	function automatic int unsigned bar_height(int unsigned peak);
		int unsigned     y;
		longint unsigned h;
		y = (peak >> PEAK_LSB) & 8'hFF;
		if (y == 0) begin
			return 0;
		end
		h = (bin_log2(y) * 64'(rows_cfg) * 64'd5) >> MAG_SH;
		return (h > 64'(rows_cfg)) ? rows_cfg : 32'(h);
	endfunction

	function automatic void settle_bar(int idx, int unsigned height, int unsigned step);
		int unsigned lv;
		int unsigned tgt;
		lv  = bar_level_q[idx];
		tgt = height << 8;
		lv  = (lv > step) ? lv - step : 0;
		bar_level_q[idx] = (tgt > lv) ? tgt : lv;
	endfunction

	// store the bin; a closing bin sweeps all bands and queues the whole bar frame
	function automatic void absorb_bin(bin_t b);
		int unsigned step;
		int          c;
		bar_t        r;
		left_mag[bin_slot]  = b.left;
		right_mag[bin_slot] = b.right;
		if (!b.last) begin
			bin_slot = bin_slot + 1'b1;
			return;
		end
		bin_slot = '0;
		step     = (falloff_cfg * rows_cfg) / 15;
		for (c = 0; c < COLS; c++) begin
			settle_bar(c, bar_height(band_peak(1'b0, c)), step);
			settle_bar(BARS - 1 - c, bar_height(band_peak(1'b1, c)), step);
		end
		for (c = 0; c < BARS; c++) begin
			r.index = INDEX_W'(c);
			r.level = LEVEL_W'(bar_level_q[c]);
			r.last  = (c == BARS - 1);
			bars_due.push_back(r);
		end
	endfunction

	function automatic logic [MAG_W-1:0] pick_mag(int style);
		int s;
		s = (style == FILL_MIXED) ? $urandom_range(FILL_TOP, FILL_SPREAD) : style;
		case (s)
			FILL_FULL: return MAG_W'($urandom_range(32767));
			FILL_ZERO: return '0;
			FILL_TOP:  return MAG_TOP;
			default:   return MAG_W'($urandom_range(32767) >> $urandom_range(14));
		endcase
	endfunction

	task automatic queue_bin(logic [MAG_W-1:0] l, logic [MAG_W-1:0] r, logic lst);
		bin_t b;
		b.left  = l;
		b.right = r;
		b.last  = lst;
		bins_pending.push_back(b);
	endtask

	task automatic queue_frame(int len, int style);
		int k;
		for (k = 0; k < len; k++) begin
			queue_bin(pick_mag(style), pick_mag(style), k == len - 1);
		end
	endtask

	task automatic note_fault(string what);
		fault_count++;
		if (fault_count <= MAX_REPORTS) begin
			$display("[%0t] %s", $realtime, what);
		end
	endtask

	task automatic wait_drained();
		while (bins_pending.size() != 0 || s_tvalid || bars_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(lbsb_cfg_t which, int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (which == CFG_ROWS) begin
			rows_cfg = val & 10'h3FF;
			foreach (bar_level_q[i]) begin
				bar_level_q[i] = 0;
			end
		end else begin
			falloff_cfg = val & 12'hFFF;
		end
		cfg_writes++;
	endtask

	// bin source: hold the transaction until accepted, idle at random between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				absorb_bin(held);
				bins_in++;
				if (held.last) begin
					frames_in++;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (bins_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					held = bins_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {2'b00, held.right, held.left};
					s_tlast  <= held.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// bar sink: compare each transaction with the oldest queued bar
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.index = m_tdata[INDEX_W-1:0];
				got.level = m_tdata[INDEX_W +: LEVEL_W];
				got.last  = m_tlast;
				bars_seen++;
				if (bars_due.size() == 0) begin
					note_fault($sformatf("unexpected bar: index %0d level %0d last %0b",
						got.index, got.level, got.last));
				end else begin
					want = bars_due.pop_front();
					if (got.index !== want.index || got.level !== want.level
							|| got.last !== want.last) begin
						note_fault($sformatf(
							"bar mismatch: exp index %0d level %0d last %0b, got %0d %0d %0b",
							want.index, want.level, want.last,
							got.index, got.level, got.last));
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		longint unsigned l255;
		int unsigned     best;
		int              i;
		int              e;
		int              p;
		int              start_count;
		send_idle_pct = 15;
		recv_idle_pct = 80;
		fault_count   = 0;
		bins_in       = 0;
		frames_in     = 0;
		bars_seen     = 0;
		cfg_writes    = 0;
		idle_cycles   = 0;
		bin_slot      = '0;
		rows_cfg      = ROWS_RESET;
		falloff_cfg   = FALLOFF_RESET;
		foreach (bar_level_q[k]) begin
			bar_level_q[k] = 0;
		end
		l255 = bin_log2(255);
		band_edge[0] = 1;
		for (i = 1; i < COLS; i++) begin
			best = 1;
			for (e = 1; e <= 255; e++) begin
				if (64'(COLS) * bin_log2(e) <= 64'(i) * l255) begin
					best = e;
				end
			end
			band_edge[i] = best;
		end
		band_edge[COLS] = 255;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// opening frame fills every bin and wraps the bin counter
		queue_frame(BINS + 2, FILL_MIXED);
		queue_bin(MAG_TOP, '0, 1'b1);
		queue_bin('0, MAG_TOP, 1'b1);
		queue_bin('0, '0, 1'b1);
		queue_frame(3, FILL_TOP);
		queue_bin(15'h5555, 15'h2AAA, 1'b0);
		queue_bin(15'h2AAA, 15'h5555, 1'b1);
		queue_frame(4, FILL_ZERO);
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		for (p = 1; p <= 5; p++) begin
			case (p)
				1: begin
					write_reg(CFG_ROWS, 1);
					write_reg(CFG_FALLOFF, 0);
				end
				2: begin
					send_idle_pct = 80;
					recv_idle_pct = 15;
					write_reg(CFG_ROWS, 1023);
					write_reg(CFG_FALLOFF, 4095);
				end
				3: begin
					write_reg(CFG_ROWS, 0);
					write_reg(CFG_FALLOFF, $urandom_range(4095));
				end
				4: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					write_reg(CFG_ROWS, $urandom_range(1023, 1));
					write_reg(CFG_FALLOFF, $urandom_range(4095));
				end
				default: begin
					write_reg(CFG_FALLOFF, $urandom_range(4095));
				end
			endcase
			start_count = bins_in + bins_pending.size() + s_tvalid;
			while (bins_in + bins_pending.size() + s_tvalid - start_count < PHASE_ITEMS) begin
				if ($urandom_range(3) == 0) begin
					// hold off until the bar frame in flight is fully out
					wait_drained();
				end
				queue_frame(($urandom_range(7) == 0) ? $urandom_range(60, 25)
					: $urandom_range(12, 1), $urandom_range(FILL_MIXED, FILL_SPREAD));
				@(posedge clk);
			end
			wait_drained();
			repeat (SETTLE) @(posedge clk);
		end

		repeat (32) @(posedge clk);
		if (bars_due.size() != 0) begin
			note_fault($sformatf("%0d bars never arrived", bars_due.size()));
		end
		$display("Run covered %0d bins in %0d frames, %0d bar transactions checked",
			bins_in, frames_in, bars_seen);
		$display("and %0d register writes across rows and falloff extremes", cfg_writes);
		if (fault_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[sim.f]
sv/lbsb_pkg.sv
sv/lbsb_spec_ram.sv
sv/lbsb_level_ram.sv
sv/lbsb_mag.sv
sv/log_band_spectrum_bars_core.sv
sv/lbsb_checker.sv
bench/tb_log_band_spectrum_bars_core.sv
